// ===== sv/gbn_pkg.sv =====
// gbn_pkg: shared types and constants for the glyph record byte-order normalizer
// depends on nothing; used by every gbn module and the core top level
package gbn_pkg;

    // default flag store depth, in points
    localparam int MAX_POINTS_DEF = 4096;
    // point counter width: holds last end point plus one
    localparam int PW = 17;
    // result queue depth and its count width
    localparam int QDEPTH = 4;
    localparam int QCW = 3;

    // glyph flag bits
    localparam logic [7:0] FL_X_SHORT = 8'h02;
    localparam logic [7:0] FL_Y_SHORT = 8'h04;
    localparam logic [7:0] FL_REPEAT = 8'h08;
    localparam logic [7:0] FL_X_SAME = 8'h10;
    localparam logic [7:0] FL_Y_SAME = 8'h20;

    // component flag bits
    localparam logic [15:0] CF_ARG_WORDS = 16'h0001;
    localparam logic [15:0] CF_SCALE = 16'h0008;
    localparam logic [15:0] CF_MORE = 16'h0020;
    localparam logic [15:0] CF_XY_SCALE = 16'h0040;
    localparam logic [15:0] CF_TWO_BY_TWO = 16'h0080;
    localparam logic [15:0] CF_INSTR = 16'h0100;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_glyph;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       was_swapped;
        logic       glyph_done;
        logic       point_overflow;
        logic       run_last;
    } out_t;

    // up to two results pushed into the queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        out_t       res0;
        out_t       res1;
    } push_t;

endpackage

// ===== sv/gbn_front.sv =====
// gbn_front: accepts record bytes, tracks the glyph layout and builds results
// depends on gbn_pkg; holds the per-point flag store
module gbn_front #(
    parameter int MAX_POINTS = gbn_pkg::MAX_POINTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gbn_pkg::in_t           in_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,
    input  logic [gbn_pkg::QCW-1:0] q_count,
    output gbn_pkg::push_t         push
);

    localparam int PW = gbn_pkg::PW;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [PW-1:0] MAXP = PW'(MAX_POINTS);

    typedef enum logic [3:0] {
        PH_HDR, PH_ENDPTS, PH_ILEN, PH_INSTR, PH_FLAGS, PH_REPEAT, PH_XC, PH_YC,
        PH_CF, PH_CIDX, PH_CBYTE, PH_CWORDS, PH_NINSTR, PH_CINSTR, PH_END, PH_LOST
    } phase_t;

    typedef enum logic [1:0] {M_ACCEPT, M_FILL, M_SETTLE} mode_t;

    // coordinate size from a stored flag: 0, 1 or 2 bytes
    function automatic logic [1:0] coord_size(logic [3:0] f, logic y);
        logic short_b;
        logic same_b;
        short_b = y ? f[1] : f[0];
        same_b = y ? f[3] : f[2];
        if (short_b) return 2'd1;
        if (same_b) return 2'd0;
        return 2'd2;
    endfunction

    function automatic logic [3:0] pack_flag(logic [7:0] f);
        return {f[5], f[4], f[2], f[1]};
    endfunction

    function automatic logic [2:0] scale_words(logic [15:0] cf);
        return 3'((cf & gbn_pkg::CF_SCALE) != 0) + 3'((cf & gbn_pkg::CF_XY_SCALE) != 0) * 3'd2
             + 3'((cf & gbn_pkg::CF_TWO_BY_TWO) != 0) * 3'd4;
    endfunction

    mode_t        mode_reg, mode_next;
    phase_t       phase_reg, phase_next;
    logic         swap_reg, swap_next;
    logic [7:0]   held_reg, held_next;
    logic         half_reg, half_next;
    logic [15:0]  contours_reg, contours_next;
    logic [15:0]  last_end_reg, last_end_next;
    logic [15:0]  count_reg, count_next;
    logic [PW-1:0] total_reg, total_next;
    logic [PW-1:0] index_reg, index_next;
    logic [7:0]   repeat_reg, repeat_next;
    logic [15:0]  cflags_reg, cflags_next;
    // results held while a fill or settle pass runs
    logic [1:0]   pn_reg, pn_next;
    logic [7:0]   pb0_reg, pb0_next, pb1_reg, pb1_next;
    logic         psw_reg, psw_next;

    logic         mem_we;
    logic [AW-1:0] mem_wa;
    logic [3:0]   mem_wd;
    logic [3:0]   rd_reg;
    logic [3:0]   flag_mem [MAX_POINTS];

    logic         emit, done;
    logic [1:0]   en;
    logic [7:0]   e0, e1;
    logic         esw;

    assign cfg_ready = 1'b1;
    assign in_ready = (mode_reg == M_ACCEPT) && (q_count <= gbn_pkg::QCW'(gbn_pkg::QDEPTH - 2));

    // parse step, fill pass and settle pass
    always_comb
    begin
        logic       acc;
        logic [7:0] b;
        logic       y;
        logic       word;
        logic [15:0] w;
        logic [2:0] sw;
        logic       go_coords;
        acc = in_valid && in_ready;
        b = in_data.data_byte;
        mode_next = mode_reg;
        phase_next = phase_reg;
        swap_next = (cfg_valid) ? cfg_data : swap_reg;
        held_next = held_reg;
        half_next = half_reg;
        contours_next = contours_reg;
        last_end_next = last_end_reg;
        count_next = count_reg;
        total_next = total_reg;
        index_next = index_reg;
        repeat_next = repeat_reg;
        cflags_next = cflags_reg;
        pn_next = pn_reg;
        pb0_next = pb0_reg;
        pb1_next = pb1_reg;
        psw_next = psw_reg;
        mem_we = 1'b0;
        mem_wa = index_reg[AW-1:0];
        mem_wd = '0;
        emit = 1'b0;
        done = 1'b0;
        en = 2'd0;
        e0 = '0;
        e1 = '0;
        esw = 1'b0;
        go_coords = 1'b0;
        w = '0;
        word = 1'b0;
        y = 1'b0;
        sw = '0;
        unique case (mode_reg)
            M_ACCEPT:
            begin
                if (acc)
                begin
                    if (in_data.start_glyph)
                    begin
                        phase_next = PH_HDR;
                        held_next = '0;
                        half_next = 1'b0;
                        contours_next = '0;
                        last_end_next = '0;
                        count_next = '0;
                        total_next = '0;
                        index_next = '0;
                        repeat_next = '0;
                        cflags_next = '0;
                    end
                    y = (phase_next == PH_YC);
                    word = (phase_next == PH_HDR) || (phase_next == PH_ENDPTS)
                        || (phase_next == PH_ILEN) || (phase_next == PH_CF)
                        || (phase_next == PH_CIDX) || (phase_next == PH_CWORDS)
                        || (phase_next == PH_NINSTR)
                        || (((phase_next == PH_XC) || (phase_next == PH_YC))
                            && (coord_size(rd_reg, y) == 2'd2));
                    if (word && !half_next)
                    begin
                        held_next = b;
                        half_next = 1'b1;
                    end
                    else if (word)
                    begin
                        half_next = 1'b0;
                        w = {held_next, b};
                        en = 2'd2;
                        esw = swap_reg;
                        e0 = swap_reg ? b : held_next;
                        e1 = swap_reg ? held_next : b;
                        emit = 1'b1;
                        unique case (phase_next)
                            PH_HDR:
                            begin
                                if (count_next == 16'd0) contours_next = w;
                                count_next = 16'(count_next + 16'd1);
                                if (count_next >= 16'd5)
                                begin
                                    count_next = '0;
                                    if (contours_next[15]) phase_next = PH_CF;
                                    else if (contours_next == 16'd0)
                                    begin
                                        total_next = '0;
                                        phase_next = PH_ILEN;
                                    end
                                    else phase_next = PH_ENDPTS;
                                end
                            end
                            PH_ENDPTS:
                            begin
                                last_end_next = w;
                                contours_next = 16'(contours_next - 16'd1);
                                if (contours_next == 16'd0)
                                begin
                                    total_next = PW'({1'b0, w}) + PW'(1);
                                    phase_next = PH_ILEN;
                                end
                            end
                            PH_ILEN:
                            begin
                                count_next = w;
                                if (w == 16'd0)
                                begin
                                    index_next = '0;
                                    if (total_next == '0)
                                    begin
                                        phase_next = PH_END;
                                        done = 1'b1;
                                    end
                                    else phase_next = PH_FLAGS;
                                end
                                else phase_next = PH_INSTR;
                            end
                            PH_XC, PH_YC:
                            begin
                                index_next = PW'(index_next + PW'(1));
                                emit = 1'b0;
                                mode_next = M_SETTLE;
                            end
                            PH_CF:
                            begin
                                cflags_next = w;
                                phase_next = PH_CIDX;
                            end
                            PH_CIDX:
                            begin
                                if ((cflags_next & gbn_pkg::CF_ARG_WORDS) != 0)
                                begin
                                    count_next = 16'd2 + 16'(scale_words(cflags_next));
                                    phase_next = PH_CWORDS;
                                end
                                else
                                begin
                                    count_next = 16'd2;
                                    phase_next = PH_CBYTE;
                                end
                            end
                            PH_CWORDS:
                            begin
                                count_next = 16'(count_next - 16'd1);
                                if (count_next == 16'd0)
                                begin
                                    if ((cflags_next & gbn_pkg::CF_MORE) != 0) phase_next = PH_CF;
                                    else if ((cflags_next & gbn_pkg::CF_INSTR) != 0)
                                        phase_next = PH_NINSTR;
                                    else
                                    begin
                                        phase_next = PH_END;
                                        done = 1'b1;
                                    end
                                end
                            end
                            PH_NINSTR:
                            begin
                                count_next = w;
                                if (w == 16'd0)
                                begin
                                    phase_next = PH_END;
                                    done = 1'b1;
                                end
                                else phase_next = PH_CINSTR;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        en = 2'd1;
                        e0 = b;
                        esw = 1'b0;
                        emit = 1'b1;
                        unique case (phase_next)
                            PH_INSTR:
                            begin
                                count_next = 16'(count_next - 16'd1);
                                if (count_next == 16'd0)
                                begin
                                    index_next = '0;
                                    if (total_next == '0)
                                    begin
                                        phase_next = PH_END;
                                        done = 1'b1;
                                    end
                                    else phase_next = PH_FLAGS;
                                end
                            end
                            PH_FLAGS:
                            begin
                                mem_we = (index_next < MAXP);
                                mem_wa = index_next[AW-1:0];
                                mem_wd = pack_flag(b);
                                index_next = PW'(index_next + PW'(1));
                                if ((b & gbn_pkg::FL_REPEAT) != 0)
                                begin
                                    held_next = b;
                                    phase_next = PH_REPEAT;
                                end
                                else if (index_next >= total_next) go_coords = 1'b1;
                            end
                            PH_REPEAT:
                            begin
                                repeat_next = b;
                                emit = 1'b0;
                                mode_next = M_FILL;
                            end
                            PH_XC, PH_YC:
                            begin
                                index_next = PW'(index_next + PW'(1));
                                emit = 1'b0;
                                mode_next = M_SETTLE;
                            end
                            PH_CBYTE:
                            begin
                                count_next = 16'(count_next - 16'd1);
                                if (count_next == 16'd0)
                                begin
                                    sw = scale_words(cflags_next);
                                    if (sw != 3'd0)
                                    begin
                                        count_next = 16'(sw);
                                        phase_next = PH_CWORDS;
                                    end
                                    else if ((cflags_next & gbn_pkg::CF_MORE) != 0)
                                        phase_next = PH_CF;
                                    else if ((cflags_next & gbn_pkg::CF_INSTR) != 0)
                                        phase_next = PH_NINSTR;
                                    else
                                    begin
                                        phase_next = PH_END;
                                        done = 1'b1;
                                    end
                                end
                            end
                            PH_CINSTR:
                            begin
                                count_next = 16'(count_next - 16'd1);
                                if (count_next == 16'd0)
                                begin
                                    phase_next = PH_END;
                                    done = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    // park results while a pass runs
                    pn_next = en;
                    pb0_next = e0;
                    pb1_next = e1;
                    psw_next = esw;
                end
            end
            M_FILL:
            begin
                en = pn_reg;
                e0 = pb0_reg;
                e1 = pb1_reg;
                esw = psw_reg;
                if ((repeat_reg != 8'd0) && (index_reg < total_reg))
                begin
                    mem_we = (index_reg < MAXP);
                    mem_wa = index_reg[AW-1:0];
                    mem_wd = pack_flag(held_reg);
                    index_next = PW'(index_reg + PW'(1));
                    repeat_next = 8'(repeat_reg - 8'd1);
                end
                else
                begin
                    repeat_next = '0;
                    mode_next = M_ACCEPT;
                    if (index_reg >= total_reg) go_coords = 1'b1;
                    else
                    begin
                        phase_next = PH_FLAGS;
                        emit = 1'b1;
                    end
                end
            end
            M_SETTLE:
            begin
                en = pn_reg;
                e0 = pb0_reg;
                e1 = pb1_reg;
                esw = psw_reg;
                y = (phase_reg == PH_YC);
                if (index_reg < total_reg)
                begin
                    if (coord_size(rd_reg, y) == 2'd0) index_next = PW'(index_reg + PW'(1));
                    else
                    begin
                        mode_next = M_ACCEPT;
                        emit = 1'b1;
                    end
                end
                else
                begin
                    index_next = '0;
                    if (!y) phase_next = PH_YC;
                    else
                    begin
                        phase_next = PH_END;
                        mode_next = M_ACCEPT;
                        emit = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = M_ACCEPT;
            end
        endcase
        // entry into the coordinates, or a lost parse on too many points
        if (go_coords)
        begin
            if (total_next > MAXP)
            begin
                phase_next = PH_LOST;
                mode_next = M_ACCEPT;
                emit = 1'b1;
            end
            else
            begin
                index_next = '0;
                phase_next = PH_XC;
                emit = 1'b0;
                mode_next = M_SETTLE;
            end
        end
    end

    // result pair for the queue
    always_comb
    begin
        logic ovf;
        ovf = (total_next > MAXP);
        push = '0;
        if (emit)
        begin
            push.n = en;
            push.res0 = '{out_byte: e0, was_swapped: esw, glyph_done: done && (en == 2'd1),
                point_overflow: ovf, run_last: (en == 2'd1)};
            push.res1 = '{out_byte: e1, was_swapped: esw, glyph_done: done,
                point_overflow: ovf, run_last: 1'b1};
        end
    end

    // flag store, read always follows the next point index
    always_ff @(posedge clk)
    begin
        if (mem_we) flag_mem[mem_wa] <= mem_wd;
        rd_reg <= (mem_we && (mem_wa == index_next[AW-1:0])) ? mem_wd
                                                           : flag_mem[index_next[AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_ACCEPT;
            phase_reg <= PH_HDR;
            swap_reg <= 1'b1;
            held_reg <= '0;
            half_reg <= 1'b0;
            contours_reg <= '0;
            last_end_reg <= '0;
            count_reg <= '0;
            total_reg <= '0;
            index_reg <= '0;
            repeat_reg <= '0;
            cflags_reg <= '0;
            pn_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            phase_reg <= phase_next;
            swap_reg <= swap_next;
            held_reg <= held_next;
            half_reg <= half_next;
            contours_reg <= contours_next;
            last_end_reg <= last_end_next;
            count_reg <= count_next;
            total_reg <= total_next;
            index_reg <= index_next;
            repeat_reg <= repeat_next;
            cflags_reg <= cflags_next;
            pn_reg <= pn_next;
        end
    end

    // parked result bytes
    always_ff @(posedge clk)
    begin
        pb0_reg <= pb0_next;
        pb1_reg <= pb1_next;
        psw_reg <= psw_next;
    end

endmodule

// ===== sv/gbn_queue.sv =====
// gbn_queue: short result queue between the parser and the output stage
// depends on gbn_pkg; takes up to two entries and gives one per cycle on pop
module gbn_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbn_pkg::push_t          push,
    input  logic                    pop,
    output logic [gbn_pkg::QCW-1:0] count,
    output gbn_pkg::out_t           head
);

    localparam int IW = $clog2(gbn_pkg::QDEPTH);

    gbn_pkg::out_t           slot_reg [gbn_pkg::QDEPTH];
    logic [IW-1:0]           wr_reg, wr_next;
    logic [IW-1:0]           rd_reg, rd_next;
    logic [gbn_pkg::QCW-1:0] count_reg, count_next;
    logic                    do_pop;

    assign count = count_reg;
    assign head = slot_reg[rd_reg];
    assign do_pop = pop && (count_reg != '0);

    // pointer and fill level update
    always_comb
    begin
        wr_next = IW'(wr_reg + IW'(push.n));
        rd_next = do_pop ? IW'(rd_reg + IW'(1)) : rd_reg;
        count_next = gbn_pkg::QCW'(count_reg + gbn_pkg::QCW'(push.n)
                                   - gbn_pkg::QCW'(do_pop));
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0) slot_reg[wr_reg] <= push.res0;
        if (push.n == 2'd2) slot_reg[IW'(wr_reg + IW'(1))] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(push.n)) <= gbn_pkg::QDEPTH)
        else $error("result queue overfilled");
    a_push_size: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("bad push size");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd0 && !do_pop) |=> $stable(count_reg))
        else $error("fill level moved without a transaction");
`endif

endmodule

// ===== sv/gbn_back.sv =====
// gbn_back: output register that drains the result queue
// depends on gbn_pkg
module gbn_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [gbn_pkg::QCW-1:0] q_count,
    input  gbn_pkg::out_t           q_head,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output gbn_pkg::out_t           out_data
);

    logic          valid_reg;
    gbn_pkg::out_t data_reg;

    // load when the register is empty or being taken
    assign q_pop = (q_count != '0) && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (!valid_reg || out_ready) valid_reg <= (q_count != '0);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) data_reg <= q_head;
    end

endmodule

// ===== sv/glyph_record_byte_order_normalizer_core.sv =====
// glyph record byte-order normalizer: top level
// depends on gbn_pkg, gbn_front, gbn_queue, gbn_back
//
// Use: bytes of a big-endian glyph record enter on in_valid/in_ready with
// in_data (data_byte, start_glyph; start_glyph marks the first header byte).
// Results leave on out_valid/out_ready with out_data; every 16-bit field comes
// out low byte first while swap is on. cfg_valid/cfg_data writes the swap
// enable (always ready, write only while idle).
// A finished result is written to the queue, then loaded into the output register.
// Throughput: one byte per cycle, while the queue has room, in header, contour,
// instruction, flag and compound sections. A repeat byte starts a fill pass
// that writes each repeated flag to the flag store (one write port), then
// resumes. The last flag byte starts a settle pass to enter the coordinates.
// A coordinate byte that ends a point starts a settle pass that reads the flag
// store, skips following points with no coordinate bytes and changes axis.
// Reset: parser returns to the header phase, swap enable is 1, no results
// pending. Flag store entries are written before being read for a glyph.
// Stall: a four-entry queue and an output register absorb a stalled
// receiver; input is held off once the queue cannot take a field pair.
module glyph_record_byte_order_normalizer_core #(
    parameter int MAX_POINTS = gbn_pkg::MAX_POINTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gbn_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output gbn_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    gbn_pkg::push_t          push;
    logic [gbn_pkg::QCW-1:0] q_count;
    gbn_pkg::out_t           q_head;
    logic                    q_pop;

    // parser and flag store
    gbn_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .q_count(q_count), .push(push)
    );

    // result queue
    gbn_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .pop(q_pop), .count(q_count), .head(q_head)
    );

    // output register
    gbn_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_count(q_count), .q_head(q_head), .q_pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
